@@ src/frame_parser_crc16_top_macros.svh @@
// Assertion macros shared by the frame parser modules.
// The clock and reset in scope must be named clk_i and rst_ni.
`ifndef FRAME_PARSER_CRC16_TOP_MACROS_SVH
`define FRAME_PARSER_CRC16_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define FPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fpc assertion failed");

`define FPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fpc assertion failed");

`else

`define FPC_ASSERT_IMP(lbl, ante, cons)
`define FPC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ src/fpc_pkg.sv @@
`default_nettype none

package fpc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 7;
  localparam int unsigned IdxW  = 6;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_FIRST    = 2'd0,
    CFG_SYNC_SECOND   = 2'd1,
    CFG_PAYLOAD_LIMIT = 2'd2
  } cfg_idx_e;

  localparam logic [ByteW-1:0] SyncFirstRst    = 8'd170;
  localparam logic [ByteW-1:0] SyncSecondRst   = 8'd85;
  localparam logic [LenW-1:0]  PayloadLimitRst = 7'd64;

  // Controller to datapath; every strobe is already qualified by an accepted item
  typedef struct packed {
    logic load_cmd;
    logic load_len_lo;
    logic load_len;
    logic wr_payload;
    logic load_crc_lo;
    logic start_emit;
  } fpc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_sync1;
    logic is_sync2;
    logic len_ok;
    logic len_zero;
    logic last_payload;
    logic crc_match;
    logic emit_done;
  } fpc_stat_t;

endpackage

`default_nettype wire

@@ src/fpc_stream_if.sv @@
`default_nettype none

interface fpc_rx_if;
  logic                       valid;
  logic                       ready;
  logic [fpc_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpc_frm_if;
  logic                       valid;
  logic                       ready;
  logic [fpc_pkg::ByteW-1:0] command;
  logic [fpc_pkg::LenW-1:0]  payload_length;
  logic                       has_data;
  logic [fpc_pkg::IdxW-1:0]  byte_index;
  logic [fpc_pkg::ByteW-1:0] data;
  logic                       last;

  modport source (output valid, output command, output payload_length, output has_data,
                  output byte_index, output data, output last, input ready);
  modport sink   (input valid, input command, input payload_length, input has_data,
                  input byte_index, input data, input last, output ready);
endinterface

`default_nettype wire

@@ src/frame_parser_crc16_top.sv @@
`default_nettype none

// Channel   Dir  Payload                                              Accept
// rx_i      in   rx_byte                                              valid & ready
// frm_o     out  command, payload_length, has_data, byte_index,       valid & ready
//                data, last
// cfg_*     in   cfg_idx_i, cfg_wdata_i                               cfg_we_i
//
// One received byte is taken per cycle while hunting and while reading a frame.
// After a frame whose CRC matches, rx_i.ready stays low through N store reads, one per
// cycle through the registered read port while frm_o does not stall, the load of the
// last item into the result register and the return to the hunt (for an empty frame,
// the load of its empty item and the return), and while frm_o holds a blocking item.
// Reset is asynchronous, active low; the store holds no reset and needs no clearing.
// A stall on frm_o holds the result register and the pending store read.

module frame_parser_crc16_top #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  fpc_rx_if.sink                            rx_i,
  fpc_frm_if.source                         frm_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [fpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [fpc_pkg::ByteW-1:0]    cfg_wdata_i
);

  fpc_pkg::fpc_cmd_t  cmd;
  fpc_pkg::fpc_stat_t stat;

  fpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .rx_ready_o (rx_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fpc_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .rx_byte_i            (rx_i.rx_byte),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .out_valid_o          (frm_o.valid),
    .out_ready_i          (frm_o.ready),
    .out_command_o        (frm_o.command),
    .out_payload_length_o (frm_o.payload_length),
    .out_has_data_o       (frm_o.has_data),
    .out_byte_index_o     (frm_o.byte_index),
    .out_data_o           (frm_o.data),
    .out_last_o           (frm_o.last)
  );

endmodule

`default_nettype wire

@@ src/fpc_ctrl.sv @@
`default_nettype none

`include "frame_parser_crc16_top_macros.svh"

module fpc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rx_valid_i,
  output logic                   rx_ready_o,
  input  wire fpc_pkg::fpc_stat_t stat_i,
  output fpc_pkg::fpc_cmd_t      cmd_o
);

  typedef enum logic [8:0] {
    ST_SYNC1   = 9'b000000001,
    ST_SYNC2   = 9'b000000010,
    ST_CMD     = 9'b000000100,
    ST_LEN_L   = 9'b000001000,
    ST_LEN_H   = 9'b000010000,
    ST_PAYLOAD = 9'b000100000,
    ST_CRC_L   = 9'b001000000,
    ST_CRC_H   = 9'b010000000,
    ST_EMIT    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  assign rx_ready_o = (state_q != ST_EMIT);
  assign acc        = rx_valid_i && rx_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_SYNC1: begin
        if (acc && stat_i.is_sync1) state_d = ST_SYNC2;
      end
      ST_SYNC2: begin
        // a repeated first sync byte keeps waiting
        if (acc) begin
          if (stat_i.is_sync2)       state_d = ST_CMD;
          else if (!stat_i.is_sync1) state_d = ST_SYNC1;
        end
      end
      ST_CMD: begin
        if (acc) begin
          cmd_o.load_cmd = 1'b1;
          state_d        = ST_LEN_L;
        end
      end
      ST_LEN_L: begin
        if (acc) begin
          cmd_o.load_len_lo = 1'b1;
          state_d           = ST_LEN_H;
        end
      end
      ST_LEN_H: begin
        if (acc) begin
          if (stat_i.len_ok) begin
            cmd_o.load_len = 1'b1;
            state_d        = stat_i.len_zero ? ST_CRC_L : ST_PAYLOAD;
          end else begin
            state_d = ST_SYNC1;
          end
        end
      end
      ST_PAYLOAD: begin
        if (acc) begin
          cmd_o.wr_payload = 1'b1;
          if (stat_i.last_payload) state_d = ST_CRC_L;
        end
      end
      ST_CRC_L: begin
        if (acc) begin
          cmd_o.load_crc_lo = 1'b1;
          state_d           = ST_CRC_H;
        end
      end
      ST_CRC_H: begin
        if (acc) begin
          if (stat_i.crc_match) begin
            cmd_o.start_emit = 1'b1;
            state_d          = ST_EMIT;
          end else begin
            state_d = ST_SYNC1;
          end
        end
      end
      ST_EMIT: begin
        if (stat_i.emit_done) state_d = ST_SYNC1;
      end
      default: state_d = ST_SYNC1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SYNC1;
    end else begin
      state_q <= state_d;
    end
  end

  `FPC_ASSERT_NXT(a_match_enters_emit, state_q == ST_CRC_H && rx_valid_i && stat_i.crc_match, state_q == ST_EMIT)
  `FPC_ASSERT_NXT(a_emit_holds, state_q == ST_EMIT && !stat_i.emit_done, state_q == ST_EMIT)
  `FPC_ASSERT_IMP(a_no_accept_in_emit, state_q == ST_EMIT, !rx_ready_o)

endmodule

`default_nettype wire

@@ src/fpc_dp.sv @@
`default_nettype none

`include "frame_parser_crc16_top_macros.svh"

module fpc_dp #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic [fpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [fpc_pkg::ByteW-1:0]    cfg_wdata_i,
  // received byte
  input  wire logic [fpc_pkg::ByteW-1:0]    rx_byte_i,
  // controller
  input  wire fpc_pkg::fpc_cmd_t            cmd_i,
  output fpc_pkg::fpc_stat_t                stat_o,
  // result
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [fpc_pkg::ByteW-1:0]         out_command_o,
  output logic [fpc_pkg::LenW-1:0]          out_payload_length_o,
  output logic                              out_has_data_o,
  output logic [fpc_pkg::IdxW-1:0]          out_byte_index_o,
  output logic [fpc_pkg::ByteW-1:0]         out_data_o,
  output logic                              out_last_o
);

  localparam int unsigned AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [fpc_pkg::LenW-1:0] MaxLen = fpc_pkg::LenW'(MAX_PAYLOAD);
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc,
                                           input logic [fpc_pkg::ByteW-1:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // configuration registers
  logic [fpc_pkg::ByteW-1:0] sync1_q, sync2_q;
  logic [fpc_pkg::LenW-1:0]  limit_q;

  // frame registers
  logic [fpc_pkg::ByteW-1:0] cmd_q, len_lo_q, crc_lo_q;
  logic [fpc_pkg::LenW-1:0]  pay_len_q, cnt_q;
  logic [15:0]               crc_q, crc_d, crc_in;
  logic                      crc_en;
  logic [fpc_pkg::LenW-1:0]  eff_limit;

  // payload store and readout
  logic [fpc_pkg::ByteW-1:0] mem [MAX_PAYLOAD];
  logic [fpc_pkg::ByteW-1:0] rdata_q;
  logic                      emit_act_q, empty_pend_q, rd_pend_q, rd_last_q;
  logic [fpc_pkg::LenW-1:0]  emit_cnt_q, emit_cnt_inc;
  logic [fpc_pkg::IdxW-1:0]  rd_idx_q;
  logic                      slot_free, move, move_empty, issue;

  // output register
  logic                      out_valid_q, out_has_data_q, out_last_q;
  logic [fpc_pkg::ByteW-1:0] out_cmd_q, out_data_q;
  logic [fpc_pkg::LenW-1:0]  out_len_q;
  logic [fpc_pkg::IdxW-1:0]  out_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync1_q <= fpc_pkg::SyncFirstRst;
      sync2_q <= fpc_pkg::SyncSecondRst;
      limit_q <= fpc_pkg::PayloadLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fpc_pkg::CFG_SYNC_FIRST:    sync1_q <= cfg_wdata_i;
        fpc_pkg::CFG_SYNC_SECOND:   sync2_q <= cfg_wdata_i;
        fpc_pkg::CFG_PAYLOAD_LIMIT: limit_q <= cfg_wdata_i[fpc_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  assign eff_limit = (limit_q > MaxLen) ? MaxLen : limit_q;
  assign crc_in    = cmd_i.load_cmd ? CrcInit : crc_q;
  assign crc_d     = crc_feed(crc_in, rx_byte_i);
  assign crc_en    = cmd_i.load_cmd | cmd_i.load_len_lo | cmd_i.load_len | cmd_i.wr_payload;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= '0;
      len_lo_q    <= '0;
      pay_len_q   <= '0;
      cnt_q       <= '0;
      crc_q       <= CrcInit;
      crc_lo_q    <= '0;
    end else begin
      if (crc_en)             crc_q       <= crc_d;
      if (cmd_i.load_cmd)     cmd_q       <= rx_byte_i;
      if (cmd_i.load_len_lo)  len_lo_q    <= rx_byte_i;
      if (cmd_i.load_crc_lo)  crc_lo_q    <= rx_byte_i;
      if (cmd_i.load_len) begin
        pay_len_q <= len_lo_q[fpc_pkg::LenW-1:0];
        cnt_q     <= '0;
      end else if (cmd_i.wr_payload) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign stat_o.is_sync1     = (rx_byte_i == sync1_q);
  assign stat_o.is_sync2     = (rx_byte_i == sync2_q);
  assign stat_o.len_ok       = (rx_byte_i == '0) && (len_lo_q <= {1'b0, eff_limit});
  assign stat_o.len_zero     = (len_lo_q == '0);
  assign stat_o.last_payload = ((cnt_q + 1'b1) >= pay_len_q);
  assign stat_o.crc_match    = ({rx_byte_i, crc_lo_q} == crc_q);
  assign stat_o.emit_done    = !emit_act_q && !empty_pend_q && !rd_pend_q;

  // readout: one store read per cycle, read data held until the output slot frees
  assign slot_free    = !out_valid_q || out_ready_i;
  assign move         = rd_pend_q && slot_free;
  assign move_empty   = empty_pend_q && slot_free;
  assign issue        = emit_act_q && (!rd_pend_q || move);
  assign emit_cnt_inc = emit_cnt_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_payload) mem[cnt_q[AddrW-1:0]] <= rx_byte_i;
    if (issue)            rdata_q <= mem[emit_cnt_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_act_q   <= 1'b0;
      empty_pend_q <= 1'b0;
      emit_cnt_q   <= '0;
      rd_pend_q    <= 1'b0;
      rd_idx_q     <= '0;
      rd_last_q    <= 1'b0;
    end else begin
      if (cmd_i.start_emit) begin
        emit_act_q   <= (pay_len_q != '0);
        empty_pend_q <= (pay_len_q == '0);
        emit_cnt_q   <= '0;
      end else begin
        if (move_empty) empty_pend_q <= 1'b0;
        if (issue) begin
          emit_cnt_q <= emit_cnt_inc;
          if (emit_cnt_inc == pay_len_q) emit_act_q <= 1'b0;
        end
      end
      if (issue) begin
        rd_pend_q <= 1'b1;
        rd_idx_q  <= emit_cnt_q[fpc_pkg::IdxW-1:0];
        rd_last_q <= (emit_cnt_inc == pay_len_q);
      end else if (move) begin
        rd_pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move || move_empty) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_cmd_q      <= cmd_q;
      out_len_q      <= pay_len_q;
      out_has_data_q <= 1'b1;
      out_idx_q      <= rd_idx_q;
      out_data_q     <= rdata_q;
      out_last_q     <= rd_last_q;
    end else if (move_empty) begin
      out_cmd_q      <= cmd_q;
      out_len_q      <= '0;
      out_has_data_q <= 1'b0;
      out_idx_q      <= '0;
      out_data_q     <= '0;
      out_last_q     <= 1'b1;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_command_o        = out_cmd_q;
  assign out_payload_length_o = out_len_q;
  assign out_has_data_o       = out_has_data_q;
  assign out_byte_index_o     = out_idx_q;
  assign out_data_o           = out_data_q;
  assign out_last_o           = out_last_q;

  `FPC_ASSERT_NXT(a_issue_sets_pending, issue, rd_pend_q)
  `FPC_ASSERT_NXT(a_rdata_held_in_stall, rd_pend_q && !slot_free, $stable(rdata_q))
  `FPC_ASSERT_NXT(a_last_read_ends_run, move && rd_last_q, out_valid_q && out_last_q && out_has_data_q)

endmodule

`default_nettype wire

@@ bench/tb_frame_parser_crc16_top.sv @@
`timescale 1ns / 100ps

module tb_frame_parser_crc16_top;

  localparam int unsigned MaxPayload   = 64;
  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'h1021;
  localparam int unsigned SettleCycles = MaxPayload + 8;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned StallLimit   = 3000;
  localparam logic [fpc_pkg::CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  typedef enum logic [2:0] {
    HUNT_SYNC1, HUNT_SYNC2, GET_CMD, GET_LEN_LO, GET_LEN_HI, GET_PAYLOAD, GET_CRC_LO, GET_CRC_HI
  } parse_step_e;

  typedef struct packed {
    logic [fpc_pkg::ByteW-1:0] command;
    logic [fpc_pkg::LenW-1:0]  payload_length;
    logic                      has_data;
    logic [fpc_pkg::IdxW-1:0]  byte_index;
    logic [fpc_pkg::ByteW-1:0] data;
    logic                      last;
  } frame_result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [fpc_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [fpc_pkg::ByteW-1:0]   cfg_wdata_i;

  fpc_rx_if  rx_ch ();
  fpc_frm_if frm_ch ();

  frame_parser_crc16_top #(
    .MAX_PAYLOAD(MaxPayload)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_ch),
    .frm_o      (frm_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Parser mirror: configuration and frame state
  logic [fpc_pkg::ByteW-1:0] sync_first_cfg    = fpc_pkg::SyncFirstRst;
  logic [fpc_pkg::ByteW-1:0] sync_second_cfg   = fpc_pkg::SyncSecondRst;
  logic [fpc_pkg::LenW-1:0]  payload_limit_cfg = fpc_pkg::PayloadLimitRst;
  parse_step_e               parse_step        = HUNT_SYNC1;
  logic [fpc_pkg::ByteW-1:0] cmd_latched;
  logic [fpc_pkg::ByteW-1:0] len_low_latched;
  logic [fpc_pkg::LenW-1:0]  exp_len;
  logic [fpc_pkg::LenW-1:0]  payload_seen;
  logic [15:0]               crc_run;
  logic [fpc_pkg::ByteW-1:0] crc_low_latched;
  logic [fpc_pkg::ByteW-1:0] payload_mem [MaxPayload];

  frame_result_t             awaited_results [$];
  logic [fpc_pkg::ByteW-1:0] rx_bytes_q [$];
  int unsigned      bytes_queued   = 0;
  int unsigned      bytes_accepted = 0;
  int unsigned      mismatches     = 0;
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      recv_hold_tag  = 0;
  int unsigned      recv_hold_seen = 0;
  int unsigned      recv_hold_left = 0;

  function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] crc,
                                                   input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [fpc_pkg::LenW-1:0] payload_cap();
    return (payload_limit_cfg > MaxPayload) ? fpc_pkg::LenW'(MaxPayload) : payload_limit_cfg;
  endfunction

  function automatic string describe_result(input frame_result_t r);
    return $sformatf("cmd=%h len=%0d has_data=%b idx=%0d data=%h last=%b",
                     r.command, r.payload_length, r.has_data, r.byte_index, r.data, r.last);
  endfunction

  function automatic bit work_pending();
    return (bytes_accepted != bytes_queued) || (awaited_results.size() != 0);
  endfunction

  function void note_reg_write(input logic [fpc_pkg::CfgIdxW-1:0] idx,
                               input logic [fpc_pkg::ByteW-1:0] value);
    case (idx)
      fpc_pkg::CFG_SYNC_FIRST: begin
        sync_first_cfg = value;
      end
      fpc_pkg::CFG_SYNC_SECOND: begin
        sync_second_cfg = value;
      end
      fpc_pkg::CFG_PAYLOAD_LIMIT: begin
        payload_limit_cfg = value[fpc_pkg::LenW-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Advance the parser mirror by one byte; queue the frame's results on a CRC match
  function void parse_rx_byte(input logic [fpc_pkg::ByteW-1:0] b);
    frame_result_t r;
    case (parse_step)
      HUNT_SYNC1: begin
        if (b == sync_first_cfg) parse_step = HUNT_SYNC2;
      end
      HUNT_SYNC2: begin
        if (b == sync_second_cfg) parse_step = GET_CMD;
        else if (b != sync_first_cfg) parse_step = HUNT_SYNC1;
      end
      GET_CMD: begin
        cmd_latched = b;
        crc_run = crc16_ccitt_byte(CrcInit, b);
        parse_step = GET_LEN_LO;
      end
      GET_LEN_LO: begin
        len_low_latched = b;
        crc_run = crc16_ccitt_byte(crc_run, b);
        parse_step = GET_LEN_HI;
      end
      GET_LEN_HI: begin
        if (b != 0 || len_low_latched > payload_cap()) begin
          parse_step = HUNT_SYNC1;
        end else begin
          crc_run = crc16_ccitt_byte(crc_run, b);
          exp_len = len_low_latched[fpc_pkg::LenW-1:0];
          payload_seen = '0;
          parse_step = (exp_len == 0) ? GET_CRC_LO : GET_PAYLOAD;
        end
      end
      GET_PAYLOAD: begin
        payload_mem[payload_seen[fpc_pkg::IdxW-1:0]] = b;
        crc_run = crc16_ccitt_byte(crc_run, b);
        payload_seen = payload_seen + 1'b1;
        if (payload_seen >= exp_len) parse_step = GET_CRC_LO;
      end
      GET_CRC_LO: begin
        crc_low_latched = b;
        parse_step = GET_CRC_HI;
      end
      default: begin
        if ({b, crc_low_latched} == crc_run) begin
          if (exp_len == 0) begin
            r = '{command: cmd_latched, payload_length: '0, has_data: 1'b0,
                  byte_index: '0, data: '0, last: 1'b1};
            awaited_results.push_back(r);
          end
          for (int k = 0; k < exp_len; k++) begin
            r = '{command: cmd_latched, payload_length: exp_len, has_data: 1'b1,
                  byte_index: fpc_pkg::IdxW'(k), data: payload_mem[k],
                  last: (k + 1 == exp_len)};
            awaited_results.push_back(r);
          end
        end
        parse_step = HUNT_SYNC1;
      end
    endcase
  endfunction

  function void push_rx_byte(input logic [fpc_pkg::ByteW-1:0] b);
    rx_bytes_q.push_back(b);
    bytes_queued++;
  endfunction

  // Build a frame with the current sync values; stop after the header if the length is refused
  function void queue_frame(input logic [fpc_pkg::ByteW-1:0] cmd, input logic [15:0] len_field,
                            input bit bad_crc, input int unsigned extra_syncs);
    logic [15:0]               crc;
    logic [fpc_pkg::ByteW-1:0] b;
    repeat (extra_syncs + 1) push_rx_byte(sync_first_cfg);
    push_rx_byte(sync_second_cfg);
    push_rx_byte(cmd);
    push_rx_byte(len_field[7:0]);
    push_rx_byte(len_field[15:8]);
    if (len_field[15:8] != 0 || len_field[7:0] > payload_cap()) return;
    crc = crc16_ccitt_byte(CrcInit, cmd);
    crc = crc16_ccitt_byte(crc, len_field[7:0]);
    crc = crc16_ccitt_byte(crc, len_field[15:8]);
    for (int i = 0; i < len_field; i++) begin
      b = 8'($urandom);
      push_rx_byte(b);
      crc = crc16_ccitt_byte(crc, b);
    end
    if (bad_crc) crc = crc ^ (16'd1 << $urandom_range(15));
    push_rx_byte(crc[7:0]);
    push_rx_byte(crc[15:8]);
  endfunction

  // Mostly well-formed frames with short payloads, the rest broken frames and line noise
  task automatic queue_random_traffic(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    int unsigned cap;
    int unsigned reps;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      pick = $urandom_range(99);
      cap  = payload_cap();
      reps = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
      if (pick < 65) begin
        queue_frame(8'($urandom), 16'($urandom_range(0, (cap < 10) ? cap : 10)), 1'b0, reps);
      end else if (pick < 75) begin
        queue_frame(8'($urandom), 16'($urandom_range(0, (cap < 6) ? cap : 6)), 1'b1, reps);
      end else if (pick < 83) begin
        queue_frame(8'($urandom), 16'($urandom_range(cap + 1, 255)), 1'b0, reps);
      end else if (pick < 88) begin
        queue_frame(8'($urandom), {8'($urandom_range(1, 255)), 8'($urandom)}, 1'b0, reps);
      end else begin
        repeat ($urandom_range(1, 4)) push_rx_byte(8'($urandom));
      end
    end
  endtask

  task automatic write_reg(input logic [fpc_pkg::CfgIdxW-1:0] idx,
                           input logic [fpc_pkg::ByteW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    note_reg_write(idx, value);
  endtask

  // Hold until every byte is taken and every result is back, then let the block go quiet
  task automatic settle();
    while (work_pending()) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_ch.valid <= 1'b0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) begin
        parse_rx_byte(rx_ch.rx_byte);
        bytes_accepted++;
      end
      if (!rx_ch.valid || rx_ch.ready) begin
        if (rx_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_ch.valid   <= 1'b1;
          rx_ch.rx_byte <= rx_bytes_q.pop_front();
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and ready control
  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst_ni) begin
      frm_ch.ready <= 1'b0;
    end else begin
      if (frm_ch.valid && frm_ch.ready) begin
        got = '{command: frm_ch.command, payload_length: frm_ch.payload_length,
                has_data: frm_ch.has_data, byte_index: frm_ch.byte_index,
                data: frm_ch.data, last: frm_ch.last};
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result: %s", $time, describe_result(got));
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch: expected %s, actual %s",
                     $time, describe_result(want), describe_result(got));
            mismatches++;
          end
        end
      end
      if (recv_hold_tag != recv_hold_seen) begin
        recv_hold_seen <= recv_hold_tag;
        recv_hold_left <= HoldCycles;
        frm_ch.ready   <= 1'b0;
      end else if (recv_hold_left != 0) begin
        recv_hold_left <= recv_hold_left - 1;
        frm_ch.ready   <= 1'b0;
      end else begin
        frm_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((rx_ch.valid && rx_ch.ready) || (frm_ch.valid && frm_ch.ready) || !work_pending())
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no progress for %0d cycles", $time, StallLimit);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [fpc_pkg::ByteW-1:0] same_sync;
    rst_ni        = 1'b0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    frm_ch.ready  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: empty frame behind a repeated first sync, oversized lengths, bad CRC
    queue_frame(8'hFF, 16'd0, 1'b0, 1);
    queue_frame(8'h00, 16'd65, 1'b0, 0);
    queue_frame(8'h5A, 16'h8001, 1'b0, 0);
    queue_frame(8'h00, 16'd1, 1'b1, 0);
    settle();

    write_reg(fpc_pkg::CFG_SYNC_FIRST, 8'($urandom));
    write_reg(fpc_pkg::CFG_SYNC_SECOND, 8'($urandom));
    write_reg(fpc_pkg::CFG_PAYLOAD_LIMIT, 8'(MaxPayload));
    write_reg(CfgIdxSpare, 8'($urandom));
    queue_random_traffic(12);
    settle();

    send_idle_pct = 72;
    write_reg(fpc_pkg::CFG_SYNC_FIRST, 8'h00);
    write_reg(fpc_pkg::CFG_SYNC_SECOND, 8'hFF);
    write_reg(fpc_pkg::CFG_PAYLOAD_LIMIT, 8'd0);
    queue_random_traffic(10);
    settle();

    // Equal sync values; a limit above the buffer size acts as the buffer size
    send_idle_pct  = 0;
    recv_stall_pct = 72;
    same_sync = 8'($urandom);
    write_reg(fpc_pkg::CFG_SYNC_FIRST, same_sync);
    write_reg(fpc_pkg::CFG_SYNC_SECOND, same_sync);
    write_reg(fpc_pkg::CFG_PAYLOAD_LIMIT, 8'hFF);
    queue_random_traffic(12);
    settle();

    send_idle_pct  = 28;
    recv_stall_pct = 28;
    write_reg(fpc_pkg::CFG_SYNC_FIRST, 8'hFF);
    write_reg(fpc_pkg::CFG_SYNC_SECOND, 8'h00);
    write_reg(fpc_pkg::CFG_PAYLOAD_LIMIT, 8'($urandom_range(1, 63)));
    queue_random_traffic(12);
    settle();

    // Full-size frame against a long receiver hold so the input backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(fpc_pkg::CFG_SYNC_FIRST, 8'hAA);
    write_reg(fpc_pkg::CFG_SYNC_SECOND, 8'h55);
    write_reg(fpc_pkg::CFG_PAYLOAD_LIMIT, 8'(MaxPayload));
    queue_frame(8'($urandom), 16'(MaxPayload), 1'b0, 0);
    queue_random_traffic(4);
    recv_hold_tag++;
    settle();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
